// File: sv/pid_step_controller_macros.svh
// Assertion macros shared by the PID step controller RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef PID_STEP_CONTROLLER_MACROS_SVH
`define PID_STEP_CONTROLLER_MACROS_SVH

// Same-cycle implication, off during reset
`define PSC_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pid_step_controller: same-cycle check failed");

// Next-cycle implication, off during reset
`define PSC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pid_step_controller: next-cycle check failed");

`endif

// File: sv/psc_pkg.sv
// Package for the PID step controller: widths, constants, command and status types.
// No dependencies.
package psc_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned DT_W        = 25;
    localparam int unsigned GAIN_W      = 32;
    localparam int unsigned MUL_W       = 32;
    localparam int unsigned PROD_W      = 2 * MUL_W;
    localparam int unsigned ACC_W       = 3 * MUL_W;
    localparam int unsigned INTEG_W     = 64;
    localparam int unsigned DIFF_W      = DATA_W + 1;
    localparam int unsigned DT_FRAC     = 24;
    localparam int unsigned QUO_W       = DIFF_W + DT_FRAC;
    localparam int unsigned INC_W       = DATA_W + DT_W;
    localparam int unsigned TERM_W      = 62;
    localparam int unsigned GAIN_SHIFT  = 20;
    localparam int unsigned INTEG_SHIFT = 44;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned DIV_CNT_W   = $clog2(QUO_W);

    localparam logic [CFG_IDX_W-1:0] CFG_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV = 2'd2;

    localparam logic [GAIN_W-1:0] KP_RESET = 32'd524288;
    localparam logic [GAIN_W-1:0] KI_RESET = 32'd1677721600;
    localparam logic [GAIN_W-1:0] KD_RESET = 32'd1049;

    localparam logic [TERM_W-1:0]  TERM_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [INTEG_W-1:0] INTEG_MAX  = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic [INTEG_W-1:0] INTEG_MIN  = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic [DATA_W-1:0]  DRIVE_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0]  DRIVE_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE,
        S_INC,
        S_INC_ACC,
        S_INTEG,
        S_P_ACC,
        S_P_TERM,
        S_P_SUM,
        S_I_HI,
        S_I_ACC,
        S_I_TERM,
        S_I_SUM,
        S_D_WAIT,
        S_D_LO,
        S_D_HI,
        S_D_ACC,
        S_D_TERM,
        S_D_SUM,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {MA_E, MA_LO, MA_HI} t_mula;
    typedef enum logic [1:0] {MB_DT, MB_KP, MB_KI, MB_KD} t_mulb;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD_HI} t_acc;
    typedef enum logic [1:0] {MAG_HOLD, MAG_INTEG, MAG_QUO} t_mag;
    typedef enum logic {SHIFT_GAIN, SHIFT_INTEG} t_shift;

    typedef struct packed {
        logic   accept;
        logic   div_start;
        t_mula  mul_a;
        t_mulb  mul_b;
        t_acc   acc_op;
        logic   integ_upd;
        t_mag   mag_op;
        logic   term_load;
        t_shift term_sh;
        logic   sum_add;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic div_busy;
    } t_stat;

endpackage

// File: sv/psc_ctrl.sv
// Sequencer for the PID step: walks one transaction through multiply, divide and sum steps.
// Depends on psc_pkg.
module psc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  psc_pkg::t_stat   i_stat,
    output psc_pkg::t_cmd    o_cmd
);

    psc_pkg::t_state r_state;
    psc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            psc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = psc_pkg::S_INC;
                end
            end
            psc_pkg::S_INC:     n_state = psc_pkg::S_INC_ACC;
            psc_pkg::S_INC_ACC: n_state = psc_pkg::S_INTEG;
            psc_pkg::S_INTEG:   n_state = psc_pkg::S_P_ACC;
            psc_pkg::S_P_ACC:   n_state = psc_pkg::S_P_TERM;
            psc_pkg::S_P_TERM:  n_state = psc_pkg::S_P_SUM;
            psc_pkg::S_P_SUM:   n_state = psc_pkg::S_I_HI;
            psc_pkg::S_I_HI:    n_state = psc_pkg::S_I_ACC;
            psc_pkg::S_I_ACC:   n_state = psc_pkg::S_I_TERM;
            psc_pkg::S_I_TERM:  n_state = psc_pkg::S_I_SUM;
            psc_pkg::S_I_SUM:   n_state = psc_pkg::S_D_WAIT;
            psc_pkg::S_D_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = psc_pkg::S_D_LO;
                end
            end
            psc_pkg::S_D_LO:    n_state = psc_pkg::S_D_HI;
            psc_pkg::S_D_HI:    n_state = psc_pkg::S_D_ACC;
            psc_pkg::S_D_ACC:   n_state = psc_pkg::S_D_TERM;
            psc_pkg::S_D_TERM:  n_state = psc_pkg::S_D_SUM;
            psc_pkg::S_D_SUM:   n_state = psc_pkg::S_DONE;
            psc_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = psc_pkg::S_IDLE;
                end
            end
            default:            n_state = psc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_a   = psc_pkg::MA_E;
        o_cmd.mul_b   = psc_pkg::MB_DT;
        o_cmd.acc_op  = psc_pkg::ACC_HOLD;
        o_cmd.mag_op  = psc_pkg::MAG_HOLD;
        o_cmd.term_sh = psc_pkg::SHIFT_GAIN;
        case (r_state)
            psc_pkg::S_IDLE: begin
                o_cmd.accept = i_valid;
            end
            psc_pkg::S_INC: begin
                o_cmd.div_start = 1'b1;
                o_cmd.mul_a     = psc_pkg::MA_E;
                o_cmd.mul_b     = psc_pkg::MB_DT;
            end
            psc_pkg::S_INC_ACC: begin
                o_cmd.acc_op = psc_pkg::ACC_LOAD;
            end
            psc_pkg::S_INTEG: begin
                o_cmd.integ_upd = 1'b1;
                o_cmd.mul_a     = psc_pkg::MA_E;
                o_cmd.mul_b     = psc_pkg::MB_KP;
            end
            psc_pkg::S_P_ACC: begin
                o_cmd.acc_op = psc_pkg::ACC_LOAD;
            end
            psc_pkg::S_P_TERM: begin
                o_cmd.term_load = 1'b1;
                o_cmd.term_sh   = psc_pkg::SHIFT_GAIN;
                o_cmd.mag_op    = psc_pkg::MAG_INTEG;
            end
            psc_pkg::S_P_SUM: begin
                o_cmd.sum_add = 1'b1;
                o_cmd.mul_a   = psc_pkg::MA_LO;
                o_cmd.mul_b   = psc_pkg::MB_KI;
            end
            psc_pkg::S_I_HI: begin
                o_cmd.acc_op = psc_pkg::ACC_LOAD;
                o_cmd.mul_a  = psc_pkg::MA_HI;
                o_cmd.mul_b  = psc_pkg::MB_KI;
            end
            psc_pkg::S_I_ACC: begin
                o_cmd.acc_op = psc_pkg::ACC_ADD_HI;
            end
            psc_pkg::S_I_TERM: begin
                o_cmd.term_load = 1'b1;
                o_cmd.term_sh   = psc_pkg::SHIFT_INTEG;
            end
            psc_pkg::S_I_SUM: begin
                o_cmd.sum_add = 1'b1;
            end
            psc_pkg::S_D_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.mag_op = psc_pkg::MAG_QUO;
                end
            end
            psc_pkg::S_D_LO: begin
                o_cmd.mul_a = psc_pkg::MA_LO;
                o_cmd.mul_b = psc_pkg::MB_KD;
            end
            psc_pkg::S_D_HI: begin
                o_cmd.acc_op = psc_pkg::ACC_LOAD;
                o_cmd.mul_a  = psc_pkg::MA_HI;
                o_cmd.mul_b  = psc_pkg::MB_KD;
            end
            psc_pkg::S_D_ACC: begin
                o_cmd.acc_op = psc_pkg::ACC_ADD_HI;
            end
            psc_pkg::S_D_TERM: begin
                o_cmd.term_load = 1'b1;
                o_cmd.term_sh   = psc_pkg::SHIFT_GAIN;
            end
            psc_pkg::S_D_SUM: begin
                o_cmd.sum_add = 1'b1;
            end
            psc_pkg::S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd.accept = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_state != psc_pkg::S_IDLE);

endmodule

// File: sv/psc_div.sv
// Restoring serial divider for the derivative: (|diff| * 2^24) / dt, one quotient bit per cycle.
// Depends on psc_pkg.
module psc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [psc_pkg::DIFF_W-1:0]   i_dividend,
    input  logic [psc_pkg::DT_W-1:0]     i_divisor,
    output logic [psc_pkg::QUO_W-1:0]    o_quotient,
    output logic                         o_busy
);

    logic [psc_pkg::QUO_W-1:0]     r_quo;
    logic [psc_pkg::DT_W-1:0]      r_rem;
    logic [psc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;

    logic [psc_pkg::DT_W:0] w_trial;
    logic [psc_pkg::DT_W:0] w_sub;
    logic                   w_ge;

    assign w_trial = {r_rem, r_quo[psc_pkg::QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});
    assign w_sub   = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == psc_pkg::DIV_CNT_W'(psc_pkg::QUO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {i_dividend, {psc_pkg::DT_FRAC{1'b0}}};
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[psc_pkg::DT_W-1:0] : w_trial[psc_pkg::DT_W-1:0];
            r_quo <= {r_quo[psc_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

endmodule

// File: sv/psc_dp.sv
// Datapath of the PID step: gains, state, shared 32x32 multiplier, integral, term sum, output.
// Depends on psc_pkg; takes the quotient from psc_div.
module psc_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  psc_pkg::t_cmd                    i_cmd,
    input  logic signed [psc_pkg::DATA_W-1:0] i_error,
    input  logic [psc_pkg::DT_W-1:0]         i_dt,
    input  logic                             i_cfg_valid,
    input  logic [psc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psc_pkg::GAIN_W-1:0]       i_cfg_data,
    input  logic [psc_pkg::QUO_W-1:0]        i_div_quo,
    output logic [psc_pkg::DIFF_W-1:0]       o_div_dividend,
    output logic [psc_pkg::DT_W-1:0]         o_div_divisor,
    output logic                             o_out_free,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [psc_pkg::DATA_W-1:0] o_drive,
    output logic                             o_drive_saturated,
    output logic                             o_dt_zero
);

    logic [psc_pkg::GAIN_W-1:0]  r_kp_mag, r_ki_mag, r_kd_mag;
    logic                        r_kp_neg, r_ki_neg, r_kd_neg;
    logic [psc_pkg::DATA_W-1:0]  r_last;
    logic [psc_pkg::INTEG_W-1:0] r_integ;
    logic                        r_out_valid;

    logic [psc_pkg::DATA_W-1:0]  r_e_mag;
    logic                        r_e_neg;
    logic [psc_pkg::DT_W-1:0]    r_dt;
    logic                        r_dz;
    logic [psc_pkg::DIFF_W-1:0]  r_diff;
    logic [psc_pkg::INTEG_W-1:0] r_mag;
    logic                        r_mag_neg;
    logic [psc_pkg::PROD_W-1:0]  r_prod;
    logic                        r_mneg;
    logic [psc_pkg::ACC_W-1:0]   r_acc;
    logic                        r_acc_neg;
    logic [psc_pkg::TERM_W-1:0]  r_term;
    logic                        r_term_neg;
    logic [psc_pkg::INTEG_W-1:0] r_sum;
    logic                        r_sat;
    logic [psc_pkg::DATA_W-1:0]  r_out_drive;
    logic                        r_out_sat;
    logic                        r_out_dz;

    logic [psc_pkg::MUL_W-1:0]   w_mul_a, w_mul_b;
    logic                        w_a_neg, w_b_neg;
    logic [psc_pkg::INTEG_W:0]   w_inc_ext, w_integ_ext, w_isum;
    logic                        w_iover;
    logic [psc_pkg::INTEG_W-1:0] w_integ_next;
    logic [psc_pkg::ACC_W-1:0]   w_shifted;
    logic                        w_term_over;
    logic [psc_pkg::INTEG_W-1:0] w_term_ext;
    logic [psc_pkg::DATA_W:0]    w_sum_hi;
    logic                        w_fits;
    logic [psc_pkg::DATA_W-1:0]  w_drive;

    // hold gains as sign and magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_mag <= psc_pkg::KP_RESET;
            r_kp_neg <= psc_pkg::KP_RESET[psc_pkg::GAIN_W-1];
            r_ki_mag <= psc_pkg::KI_RESET;
            r_ki_neg <= psc_pkg::KI_RESET[psc_pkg::GAIN_W-1];
            r_kd_mag <= psc_pkg::KD_RESET;
            r_kd_neg <= psc_pkg::KD_RESET[psc_pkg::GAIN_W-1];
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psc_pkg::CFG_PROP: begin
                    r_kp_mag <= i_cfg_data[psc_pkg::GAIN_W-1] ? -i_cfg_data : i_cfg_data;
                    r_kp_neg <= i_cfg_data[psc_pkg::GAIN_W-1];
                end
                psc_pkg::CFG_INTEG: begin
                    r_ki_mag <= i_cfg_data[psc_pkg::GAIN_W-1] ? -i_cfg_data : i_cfg_data;
                    r_ki_neg <= i_cfg_data[psc_pkg::GAIN_W-1];
                end
                psc_pkg::CFG_DERIV: begin
                    r_kd_mag <= i_cfg_data[psc_pkg::GAIN_W-1] ? -i_cfg_data : i_cfg_data;
                    r_kd_neg <= i_cfg_data[psc_pkg::GAIN_W-1];
                end
                default: begin
                    r_kp_neg <= r_kp_neg;
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.mul_a)
            psc_pkg::MA_E: begin
                w_mul_a = r_e_mag;
                w_a_neg = r_e_neg;
            end
            psc_pkg::MA_LO: begin
                w_mul_a = r_mag[psc_pkg::MUL_W-1:0];
                w_a_neg = r_mag_neg;
            end
            psc_pkg::MA_HI: begin
                w_mul_a = r_mag[psc_pkg::INTEG_W-1:psc_pkg::MUL_W];
                w_a_neg = r_mag_neg;
            end
            default: begin
                w_mul_a = '0;
                w_a_neg = 1'b0;
            end
        endcase
        case (i_cmd.mul_b)
            psc_pkg::MB_DT: begin
                w_mul_b = {{(psc_pkg::MUL_W-psc_pkg::DT_W){1'b0}}, r_dt};
                w_b_neg = 1'b0;
            end
            psc_pkg::MB_KP: begin
                w_mul_b = r_kp_mag;
                w_b_neg = r_kp_neg;
            end
            psc_pkg::MB_KI: begin
                w_mul_b = r_ki_mag;
                w_b_neg = r_ki_neg;
            end
            psc_pkg::MB_KD: begin
                w_mul_b = r_kd_mag;
                w_b_neg = r_kd_neg;
            end
            default: begin
                w_mul_b = '0;
                w_b_neg = 1'b0;
            end
        endcase
    end

    assign w_inc_ext   = {{(psc_pkg::INTEG_W+1-psc_pkg::INC_W){1'b0}},
                          r_acc[psc_pkg::INC_W-1:0]};
    assign w_integ_ext = {r_integ[psc_pkg::INTEG_W-1], r_integ};
    assign w_isum      = r_acc_neg ? (w_integ_ext - w_inc_ext) : (w_integ_ext + w_inc_ext);
    assign w_iover     = w_isum[psc_pkg::INTEG_W] ^ w_isum[psc_pkg::INTEG_W-1];
    assign w_integ_next = !w_iover ? w_isum[psc_pkg::INTEG_W-1:0] :
                          (w_isum[psc_pkg::INTEG_W] ? psc_pkg::INTEG_MIN : psc_pkg::INTEG_MAX);

    assign w_shifted   = (i_cmd.term_sh == psc_pkg::SHIFT_INTEG) ?
                         (r_acc >> psc_pkg::INTEG_SHIFT) : (r_acc >> psc_pkg::GAIN_SHIFT);
    assign w_term_over = (|w_shifted[psc_pkg::ACC_W-1:psc_pkg::TERM_W]) |
                         (w_shifted[psc_pkg::TERM_W-1] & (|w_shifted[psc_pkg::TERM_W-2:0]));
    assign w_term_ext  = {{(psc_pkg::INTEG_W-psc_pkg::TERM_W){1'b0}}, r_term};

    assign w_sum_hi = r_sum[psc_pkg::INTEG_W-1:psc_pkg::DATA_W-1];
    assign w_fits   = (&w_sum_hi) | (~|w_sum_hi);
    assign w_drive  = w_fits ? r_sum[psc_pkg::DATA_W-1:0] :
                      (r_sum[psc_pkg::INTEG_W-1] ? psc_pkg::DRIVE_MIN : psc_pkg::DRIVE_MAX);

    // controller state carried between transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last <= i_error;
            end
            if (i_cmd.integ_upd) begin
                r_integ <= w_integ_next;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {{psc_pkg::MUL_W{1'b0}}, w_mul_a} * {{psc_pkg::MUL_W{1'b0}}, w_mul_b};
        r_mneg <= w_a_neg ^ w_b_neg;
        if (i_cmd.accept) begin
            r_e_mag <= i_error[psc_pkg::DATA_W-1] ? -i_error : i_error;
            r_e_neg <= i_error[psc_pkg::DATA_W-1];
            r_dt    <= i_dt;
            r_dz    <= (i_dt == '0);
            r_diff  <= {i_error[psc_pkg::DATA_W-1], i_error} -
                       {r_last[psc_pkg::DATA_W-1], r_last};
            r_sum   <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_cmd.integ_upd && w_iover) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.sum_add) begin
                r_sum <= r_term_neg ? (r_sum - w_term_ext) : (r_sum + w_term_ext);
            end
        end
        case (i_cmd.acc_op)
            psc_pkg::ACC_LOAD: begin
                r_acc     <= {{psc_pkg::MUL_W{1'b0}}, r_prod};
                r_acc_neg <= r_mneg;
            end
            psc_pkg::ACC_ADD_HI: begin
                r_acc <= r_acc + {r_prod, {psc_pkg::MUL_W{1'b0}}};
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        case (i_cmd.mag_op)
            psc_pkg::MAG_INTEG: begin
                r_mag     <= r_integ[psc_pkg::INTEG_W-1] ? -r_integ : r_integ;
                r_mag_neg <= r_integ[psc_pkg::INTEG_W-1];
            end
            psc_pkg::MAG_QUO: begin
                r_mag     <= r_dz ? '0 :
                             {{(psc_pkg::INTEG_W-psc_pkg::QUO_W){1'b0}}, i_div_quo};
                r_mag_neg <= r_diff[psc_pkg::DIFF_W-1];
            end
            default: begin
                r_mag <= r_mag;
            end
        endcase
        if (i_cmd.term_load) begin
            r_term     <= w_term_over ? psc_pkg::TERM_LIMIT : w_shifted[psc_pkg::TERM_W-1:0];
            r_term_neg <= r_acc_neg;
        end
        if (i_cmd.out_load) begin
            r_out_drive <= w_drive;
            r_out_sat   <= r_sat | !w_fits;
            r_out_dz    <= r_dz;
        end
    end

    assign o_div_dividend    = r_diff[psc_pkg::DIFF_W-1] ? -r_diff : r_diff;
    assign o_div_divisor     = r_dt;
    assign o_out_free        = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_drive           = r_out_drive;
    assign o_drive_saturated = r_out_sat;
    assign o_dt_zero         = r_out_dz;

endmodule

// File: sv/pid_step_controller.sv
// PID step controller top level: sequencer, serial divider and datapath; uses psc_pkg and macros.
// An accepted transaction runs through the sequencer states to o_valid; the next one is taken only
// back in idle, so throughput is set by the 57-step serial divider that forms the derivative quotient.
// The result sits in an output register, so the next transaction is taken while it waits.
// Synchronous active-low reset restores default gains and clears integral and last error.
`include "pid_step_controller_macros.svh"

module pid_step_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [psc_pkg::DATA_W-1:0]  i_error,
    input  logic [psc_pkg::DT_W-1:0]           i_dt,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [psc_pkg::DATA_W-1:0]  o_drive,
    output logic                               o_drive_saturated,
    output logic                               o_dt_zero,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [psc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psc_pkg::GAIN_W-1:0]         i_cfg_data
);

    psc_pkg::t_cmd  w_cmd;
    psc_pkg::t_stat w_stat;

    logic [psc_pkg::DIFF_W-1:0] w_dividend;
    logic [psc_pkg::DT_W-1:0]   w_divisor;
    logic [psc_pkg::QUO_W-1:0]  w_quotient;
    logic                       w_div_busy;
    logic                       w_out_free;

    assign w_stat.out_free = w_out_free;
    assign w_stat.div_busy = w_div_busy;
    assign o_cfg_ready     = 1'b1;

    psc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    psc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quotient),
        .o_busy     (w_div_busy)
    );

    psc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_error           (i_error),
        .i_dt              (i_dt),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_div_quo         (w_quotient),
        .o_div_dividend    (w_dividend),
        .o_div_divisor     (w_divisor),
        .o_out_free        (w_out_free),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_drive           (o_drive),
        .o_drive_saturated (o_drive_saturated),
        .o_dt_zero         (o_dt_zero)
    );

    `PSC_ASSERT_NEXT(a_accept_then_busy, i_valid && !o_stall, o_stall)
    `PSC_ASSERT_IMPLY(a_load_after_divide, w_cmd.out_load, !w_div_busy && o_stall)
    `PSC_ASSERT_NEXT(a_start_runs_divider, w_cmd.div_start, w_div_busy)

endmodule

// File: tb/sv/pid_step_checker.sv
// Checker for the PID step controller: watches the gain writes, the error/interval
// transactions and the drive transactions, predicts each drive and compares it.
// Depends on psc_pkg for widths, register indexes and saturation bounds.
module pid_step_checker
    import psc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic signed [DATA_W-1:0]  i_error,
    input  logic [DT_W-1:0]           i_dt,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [DATA_W-1:0]  i_drive,
    input  logic                      i_drive_saturated,
    input  logic                      i_dt_zero,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [GAIN_W-1:0]         i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_clipped,
    output int                        o_zero_dt
);

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     saturated;
        logic                     dt_zero;
    } t_pid_result;

    localparam logic signed [INTEG_W+1:0] INTEG_HI = $signed({2'b00, INTEG_MAX});
    localparam logic signed [INTEG_W+1:0] INTEG_LO = $signed({2'b11, INTEG_MIN});
    localparam logic signed [63:0]        DRIVE_HI = $signed({32'b0, DRIVE_MAX});
    localparam logic signed [63:0]        DRIVE_LO = $signed({{32{1'b1}}, DRIVE_MIN});

    logic signed [GAIN_W-1:0]  kp, ki, kd;
    logic signed [DATA_W-1:0]  held_err;
    logic signed [INTEG_W-1:0] integ;
    t_pid_result               expected_drives[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s, got %h, expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Exact product, magnitude truncated by sh bits and clamped to the term limit.
    function automatic logic signed [63:0] scaled_term(input logic signed [63:0] a,
                                                       input logic signed [31:0] g,
                                                       input int unsigned sh);
        logic         neg;
        logic [63:0]  ma;
        logic [31:0]  mg;
        logic [127:0] prod;
        logic signed [63:0] r;
        neg  = (a < 0) != (g < 0);
        ma   = (a < 0) ? -a : a;
        mg   = (g < 0) ? -g : g;
        prod = ({64'b0, ma} * {96'b0, mg}) >> sh;
        if (prod > {66'b0, TERM_LIMIT}) begin
            prod = {66'b0, TERM_LIMIT};
        end
        r = $signed(prod[63:0]);
        return neg ? -r : r;
    endfunction

    function automatic t_pid_result pid_step(input logic signed [DATA_W-1:0] err,
                                             input logic [DT_W-1:0] dt);
        logic signed [INTEG_W+1:0] inc, sum;
        logic signed [DATA_W:0]    diff;
        logic [DATA_W:0]           mag;
        logic [63:0]               num, quo;
        logic signed [63:0]        deriv, tp, ti, td, u;
        t_pid_result               r;
        r.dt_zero   = (dt == '0);
        r.saturated = 1'b0;
        inc = err * $signed({1'b0, dt});
        sum = integ + inc;
        if (sum > INTEG_HI) begin
            integ = INTEG_MAX;
            r.saturated = 1'b1;
        end else if (sum < INTEG_LO) begin
            integ = INTEG_MIN;
            r.saturated = 1'b1;
        end else begin
            integ = sum[INTEG_W-1:0];
        end
        deriv = '0;
        if (!r.dt_zero) begin
            diff  = err - held_err;
            mag   = (diff < 0) ? -diff : diff;
            num   = {31'b0, mag} << DT_FRAC;
            quo   = num / {39'b0, dt};
            deriv = (diff < 0) ? -$signed(quo) : $signed(quo);
        end
        held_err = err;
        tp = scaled_term(err, kp, GAIN_SHIFT);
        ti = scaled_term(integ, ki, INTEG_SHIFT);
        td = scaled_term(deriv, kd, GAIN_SHIFT);
        u  = tp + ti + td;
        if (u > DRIVE_HI) begin
            u = DRIVE_HI;
            r.saturated = 1'b1;
        end else if (u < DRIVE_LO) begin
            u = DRIVE_LO;
            r.saturated = 1'b1;
        end
        r.drive = u[DATA_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pid_result want;
        if (!i_rst_n) begin
            kp         = KP_RESET;
            ki         = KI_RESET;
            kd         = KD_RESET;
            held_err   = '0;
            integ      = '0;
            expected_drives.delete();
            o_pending  = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_drives.size() == 0) begin
                    report_mismatch("drive transaction with none expected", i_drive, '0);
                end else begin
                    want = expected_drives.pop_front();
                    if (i_drive !== want.drive) begin
                        report_mismatch("drive", i_drive, want.drive);
                    end
                    if (i_drive_saturated !== want.saturated) begin
                        report_mismatch("drive_saturated", i_drive_saturated, want.saturated);
                    end
                    if (i_dt_zero !== want.dt_zero) begin
                        report_mismatch("dt_zero", i_dt_zero, want.dt_zero);
                    end
                    o_checked++;
                    if (want.saturated) o_clipped++;
                    if (want.dt_zero) o_zero_dt++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROP:  kp = i_cfg_data;
                    CFG_INTEG: ki = i_cfg_data;
                    CFG_DERIV: kd = i_cfg_data;
                    default:   ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_drives.push_back(pid_step(i_error, i_dt));
            end
            o_pending = expected_drives.size();
        end
    end

endmodule

// File: tb/sv/pid_step_controller_tb.sv
// Testbench top for the PID step controller: clock, reset, gain writes and error/interval
// stimulus under varying idle and stall patterns. Uses psc_pkg and pid_step_checker.
module pid_step_controller_tb;
    import psc_pkg::*;

    typedef enum int {K_NOISE, K_SMALL, K_WINDUP, K_STEADY} t_item_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam logic [DATA_W-1:0]    ERR_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]    ERR_MIN     = 32'h8000_0000;
    localparam logic [DT_W-1:0]      DT_FULL     = 25'h1FF_FFFF;
    localparam logic [DT_W-1:0]      DT_ONE_SEC  = 25'h100_0000;
    localparam int                   CYCLE_LIMIT = 1_000_000;
    localparam int                   HOLD_CYCLES = 500;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_error;
    logic [DT_W-1:0]          i_dt;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_drive;
    logic                     o_drive_saturated;
    logic                     o_dt_zero;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [GAIN_W-1:0]        i_cfg_data;

    int fail_count, pending, checked, clipped, zero_dt;
    int cycle_count, gain_settings;
    int tx_idle_pct = 10;
    int rx_idle_pct = 88;
    int hold_left   = 0;
    bit hold_start  = 1'b0;
    bit hold_taken  = 1'b0;

    t_item_kind               chunk_kind;
    int                       chunk_left = 0;
    bit                       chunk_neg;
    logic signed [DATA_W-1:0] walk_err = '0;

    always #6 i_clk = ~i_clk;

    pid_step_controller i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_error           (i_error),
        .i_dt              (i_dt),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_drive           (o_drive),
        .o_drive_saturated (o_drive_saturated),
        .o_dt_zero         (o_dt_zero),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    pid_step_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_error           (i_error),
        .i_dt              (i_dt),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_drive           (o_drive),
        .i_drive_saturated (o_drive_saturated),
        .i_dt_zero         (o_dt_zero),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_clipped         (clipped),
        .o_zero_dt         (zero_dt)
    );

    // Receiver: random stall, or a long hold once requested.
    always @(negedge i_clk) begin
        if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic signed [DATA_W-1:0] e, input logic [DT_W-1:0] dt);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (tx_idle_pct > 50 && $urandom_range(19) == 0) gap = $urandom_range(60, 140);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_error <= e;
        i_dt    <= dt;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(negedge i_clk);
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd);
        write_reg(CFG_PROP, kp);
        write_reg(CFG_INTEG, ki);
        write_reg(CFG_DERIV, kd);
        gain_settings++;
    endtask

    function automatic logic [GAIN_W-1:0] extreme_gain();
        case ($urandom_range(4))
            0:       return ERR_MAX;
            1:       return ERR_MIN;
            2:       return '0;
            3:       return 32'd1;
            default: return '1;
        endcase
    endfunction

    task automatic pick_gains(input int seg);
        case (seg % 4)
            1:       write_gains($urandom, $urandom, $urandom);
            2:       write_gains(extreme_gain(), extreme_gain(), extreme_gain());
            default: write_gains($urandom_range(0, 2 << 20) - (1 << 20),
                                 $urandom_range(0, 1 << 13) - (1 << 12),
                                 $urandom_range(0, 1 << 17) - (1 << 16));
        endcase
    endtask

    // Mostly coherent runs: small errors, steady loops, and long windups toward saturation.
    task automatic next_item(output logic signed [DATA_W-1:0] e, output logic [DT_W-1:0] dt);
        logic [DATA_W-1:0] mag;
        if (chunk_left == 0) begin
            chunk_kind = t_item_kind'($urandom_range(3));
            chunk_left = (chunk_kind == K_WINDUP) ? $urandom_range(60, 220)
                                                  : $urandom_range(1, 40);
            chunk_neg  = 1'($urandom_range(1));
            walk_err   = $urandom_range(0, 1 << 22) - (1 << 21);
        end
        chunk_left--;
        case (chunk_kind)
            K_NOISE: begin
                e  = $urandom;
                dt = ($urandom_range(15) == 0) ? '0 : DT_W'($urandom_range(0, DT_FULL));
            end
            K_SMALL: begin
                e  = $urandom_range(0, 1 << 21) - (1 << 20);
                dt = DT_W'($urandom_range(1, 1 << 16));
            end
            K_WINDUP: begin
                mag = $urandom_range(32'h7000_0000, ERR_MAX);
                e   = chunk_neg ? -mag : mag;
                if ($urandom_range(15) == 0) e = chunk_neg ? ERR_MIN : ERR_MAX;
                dt  = ($urandom_range(31) == 0) ? '0
                                                : DT_W'($urandom_range(25'h180_0000, DT_FULL));
            end
            default: begin
                walk_err = walk_err + $signed($urandom_range(0, 2000)) - 1000;
                e  = walk_err;
                dt = DT_W'($urandom_range(16000, 17600));
            end
        endcase
    endtask

    initial begin
        logic signed [DATA_W-1:0] e;
        logic [DT_W-1:0]          dt;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_error     = '0;
        i_dt        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        gain_settings = 1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default gains: zero interval, extreme errors and intervals, full derivative swings
        send_item('0, '0);
        send_item(ERR_MAX, DT_FULL);
        send_item(ERR_MIN, DT_FULL);
        send_item(ERR_MIN, 25'd1);
        send_item(ERR_MAX, 25'd1);
        send_item(ERR_MIN, 25'd1);
        send_item(-32'sd1, '0);
        send_item(32'sd1, DT_ONE_SEC);
        send_item('0, DT_ONE_SEC);
        wait_results_done();

        write_gains(ERR_MAX, ERR_MIN, ERR_MAX);
        write_reg(CFG_UNUSED, $urandom);
        send_item(ERR_MAX, 25'd1);
        send_item(ERR_MIN, 25'd1);
        send_item('0, '0);
        send_item(32'sd12345, 25'd16777);
        send_item(ERR_MIN, DT_FULL);
        send_item(ERR_MIN, DT_FULL);
        wait_results_done();

        write_gains(ERR_MIN, ERR_MAX, ERR_MIN);
        send_item(ERR_MAX, DT_FULL);
        send_item(ERR_MIN, 25'd1);
        send_item(32'sd65536, '0);
        send_item(-32'sd65536, DT_ONE_SEC);
        send_item('0, 25'd1);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 88 : 0;
            rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 10 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                wait_results_done();
                pick_gains(seg);
                if (ph == 2 && seg == 0) begin
                    @(posedge i_clk);
                    hold_start = 1'b1;
                end
                repeat (170) begin
                    next_item(e, dt);
                    send_item(e, dt);
                end
            end
        end

        wait_results_done();
        repeat (80) @(posedge i_clk);
        $display("Run covered %0d checked steps over %0d gain settings (extremes included),",
                 checked, gain_settings);
        $display("with %0d clipped results and %0d zero-interval steps.", clipped, zero_dt);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/psc_pkg.sv
sv/psc_ctrl.sv
sv/psc_div.sv
sv/psc_dp.sv
sv/pid_step_controller.sv
tb/sv/pid_step_checker.sv
tb/sv/pid_step_controller_tb.sv
